// File: rtl/lbm_pkg.sv
// Package for the CPU load-balance migrator.
// Holds the shared timestamp type and the fixed constants of the block.
// Depends on nothing.
package lbm_pkg;

	// 64-bit timestamps, busy times and thread times.
	typedef logic [63:0] stamp_t;

	// Number of CPUs tracked by the block.
	localparam int NUM_CPUS = 8;

	// Command codes of the input transaction.
	localparam logic CMD_CHARGE = 1'b0;
	localparam logic CMD_AWARD  = 1'b1;

	// Reset value of the activation window register.
	localparam logic [31:0] WINDOW_RESET = 32'd200000;

	// Width used to widen CPU indexes and picks before compares and part-selects.
	localparam int IDX_EXT_W = 8;

endpackage

// File: rtl/cpu_load_balance_migrator_top.sv
// CPU load-balance migrator: the top level and its only module.
// Depends on lbm_pkg for the timestamp type and constants.
//
// A charge passes S_RD, S_DELTA, S_BUSY, S_TT, S_WIN and S_WCMP, then, when the window
// has elapsed, the scan that reads one busy-time entry per cycle, then S_OUT; an award
// passes S_AW0 to S_AW3 and S_OUT; a no-op event goes straight to S_OUT. One transaction
// is in progress at a time; the next can be taken as the result appears, later while
// an earlier result is still stalled. All wide sums run through one shared 64-bit adder.
// Reset: arst_n clears all busy times and dispatch stamps (per-entry valid bits),
// the window start and both picks, and loads the activation window with 200000.
module cpu_load_balance_migrator_top (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// Configuration write channel.
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [31:0]                                cfg_data,
	// Input channel.
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic                                       cmd,
	input  logic                                       is_end,
	input  logic [2:0]                                 cpu_index,
	input  lbm_pkg::stamp_t                            now_stamp,
	input  lbm_pkg::stamp_t                            thread_time_in,
	// Output channel.
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic                                       decision,
	output lbm_pkg::stamp_t                            thread_time_out,
	output logic [2:0]                                 migrate_target,
	output logic [$clog2(lbm_pkg::NUM_CPUS + 1) - 1:0] least_cpu_out,
	output logic [$clog2(lbm_pkg::NUM_CPUS + 1) - 1:0] most_cpu_out
);

	import lbm_pkg::*;

	localparam int CIDX_W = $clog2(NUM_CPUS);
	localparam int PICK_W = $clog2(NUM_CPUS + 1);
	localparam logic [PICK_W-1:0] PICK_NONE = PICK_W'(NUM_CPUS);
	localparam logic [IDX_EXT_W-1:0] NUM_EXT = IDX_EXT_W'(NUM_CPUS);

	// Sequencer state codes.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_DELTA = 4'd2;
	localparam logic [3:0] S_BUSY  = 4'd3;
	localparam logic [3:0] S_TT    = 4'd4;
	localparam logic [3:0] S_WIN   = 4'd5;
	localparam logic [3:0] S_WCMP  = 4'd6;
	localparam logic [3:0] S_SCAN  = 4'd7;
	localparam logic [3:0] S_AW0   = 4'd8;
	localparam logic [3:0] S_AW1   = 4'd9;
	localparam logic [3:0] S_AW2   = 4'd10;
	localparam logic [3:0] S_AW3   = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	logic [3:0]            state_q;

	// Captured input transaction.
	logic [2:0]            cpu_q;
	stamp_t                now_q;
	stamp_t                tt_q;

	// Block state.
	logic [31:0]           window_q;
	stamp_t                ws_q;
	logic [PICK_W-1:0]     least_pick_q;
	logic [PICK_W-1:0]     most_pick_q;

	// Working registers.
	stamp_t                delta_q;
	stamp_t                diff_q;
	stamp_t                bhi_q;
	stamp_t                sum_q;
	logic                  ok_q;
	logic                  res_dec_q;
	logic [PICK_W-1:0]     res_tgt_q;

	// Scan registers.
	logic [PICK_W-1:0]     scan_idx_q;
	logic                  pend_s1;
	logic [PICK_W-1:0]     idx_s1;
	stamp_t                min_q;
	stamp_t                max_q;
	logic [PICK_W-1:0]     lo_q;
	logic [PICK_W-1:0]     hi_q;

	// Output registers.
	logic                  out_valid_q;
	logic                  decision_q;
	stamp_t                tt_out_q;
	logic [2:0]            target_q;
	logic [PICK_W-1:0]     least_out_q;
	logic [PICK_W-1:0]     most_out_q;

	// Busy-time and dispatch-stamp memories with per-entry valid bits.
	stamp_t                busy_mem [NUM_CPUS];
	stamp_t                disp_mem [NUM_CPUS];
	logic [NUM_CPUS-1:0]   busy_vld_q;
	logic [NUM_CPUS-1:0]   disp_vld_q;
	stamp_t                busy_rd_q;
	stamp_t                disp_rd_q;

	logic [IDX_EXT_W-1:0]  cpu_in_ext;
	logic [IDX_EXT_W-1:0]  cpu_ext;
	logic [IDX_EXT_W-1:0]  rd_idx;
	logic [CIDX_W-1:0]     rd_addr;
	logic [CIDX_W-1:0]     cpu_addr;
	logic                  rd_ok;
	logic                  accept;
	logic                  scan_issue;
	logic                  out_free;
	logic                  mig;

	// Shared 64-bit adder/subtractor.
	stamp_t                alu_a;
	stamp_t                alu_b;
	logic                  alu_sub;
	logic [64:0]           alu_sum;
	logic                  alu_carry;
	stamp_t                alu_res;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_free   = !out_valid_q || !out_stall;
	assign cpu_in_ext = IDX_EXT_W'(cpu_index);
	assign cpu_ext    = IDX_EXT_W'(cpu_q);
	assign cpu_addr   = cpu_ext[CIDX_W-1:0];
	assign scan_issue = (scan_idx_q < PICK_NONE);

	// Read address selection for the busy-time memory.
	always_comb begin
		case (state_q)
			S_RD:    rd_idx = cpu_ext;
			S_AW0:   rd_idx = IDX_EXT_W'(most_pick_q);
			S_AW1:   rd_idx = IDX_EXT_W'(least_pick_q);
			S_SCAN:  rd_idx = IDX_EXT_W'(scan_idx_q);
			default: rd_idx = cpu_ext;
		endcase
	end
	assign rd_addr = rd_idx[CIDX_W-1:0];
	assign rd_ok   = (rd_idx < NUM_EXT);

	// Operand selection for the shared adder.
	always_comb begin
		alu_a   = now_q;
		alu_b   = delta_q;
		alu_sub = 1'b0;
		case (state_q)
			S_DELTA: begin
				alu_a   = now_q;
				alu_b   = disp_rd_q;
				alu_sub = 1'b1;
			end
			S_BUSY: begin
				alu_a = busy_rd_q;
				alu_b = delta_q;
			end
			S_TT: begin
				alu_a = tt_q;
				alu_b = delta_q;
			end
			S_WIN: begin
				alu_a   = now_q;
				alu_b   = ws_q;
				alu_sub = 1'b1;
			end
			S_WCMP: begin
				alu_a   = diff_q;
				alu_b   = {32'd0, window_q};
				alu_sub = 1'b1;
			end
			S_AW2: begin
				alu_a = busy_rd_q;
				alu_b = tt_q;
			end
			S_AW3: begin
				alu_a   = bhi_q;
				alu_b   = sum_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = now_q;
				alu_b   = delta_q;
				alu_sub = 1'b0;
			end
		endcase
	end
	assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {64{alu_sub}}} + {64'd0, alu_sub};
	assign alu_carry = alu_sum[64];
	assign alu_res   = alu_sum[63:0];

	// Migration is proposed when the picks are valid and distinct, the event CPU is
	// the most-used one and its busy time covers the least-used time plus the thread.
	assign mig = ok_q && alu_carry;

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (state_q == S_BUSY) begin
			busy_mem[cpu_addr] <= alu_res;
		end
		if (state_q == S_AW0) begin
			disp_mem[cpu_addr] <= now_q;
		end
		busy_rd_q <= (rd_ok && busy_vld_q[rd_addr]) ? busy_mem[rd_addr] : '0;
		disp_rd_q <= disp_vld_q[cpu_addr] ? disp_mem[cpu_addr] : '0;
	end

	// Valid bits of the two memories.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_vld_q <= '0;
			disp_vld_q <= '0;
		end else begin
			if (state_q == S_BUSY) begin
				busy_vld_q[cpu_addr] <= 1'b1;
			end
			if (state_q == S_AW0) begin
				disp_vld_q[cpu_addr] <= 1'b1;
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	// Working and payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (accept) begin
			cpu_q <= cpu_index;
			now_q <= now_stamp;
			tt_q  <= thread_time_in;
		end
		case (state_q)
			S_DELTA: delta_q <= alu_res;
			S_TT:    tt_q    <= alu_res;
			S_WIN:   diff_q  <= alu_res;
			S_AW0: begin
				ok_q <= (least_pick_q < PICK_NONE) && (most_pick_q < PICK_NONE) &&
					(IDX_EXT_W'(most_pick_q) == cpu_ext) && (least_pick_q != most_pick_q);
			end
			S_AW1:   bhi_q   <= busy_rd_q;
			S_AW2:   sum_q   <= alu_res;
			default: begin
			end
		endcase
		// Scan over the busy times: one entry read per cycle, compared once its registered read returns.
		if (state_q == S_WCMP) begin
			scan_idx_q <= '0;
			min_q      <= '1;
			max_q      <= '0;
			lo_q       <= PICK_NONE;
			hi_q       <= PICK_NONE;
		end else if (state_q == S_SCAN) begin
			scan_idx_q <= scan_idx_q + PICK_W'(1);
			idx_s1     <= scan_idx_q;
			if (pend_s1) begin
				if (busy_rd_q < min_q) begin
					min_q <= busy_rd_q;
					lo_q  <= idx_s1;
				end
				if (busy_rd_q > max_q) begin
					max_q <= busy_rd_q;
					hi_q  <= idx_s1;
				end
			end
		end
		if (state_q == S_OUT && out_free) begin
			decision_q  <= res_dec_q;
			tt_out_q    <= tt_q;
			target_q    <= 3'(IDX_EXT_W'(res_tgt_q));
			least_out_q <= least_pick_q;
			most_out_q  <= most_pick_q;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ws_q         <= '0;
			least_pick_q <= '0;
			most_pick_q  <= '0;
			res_dec_q    <= 1'b0;
			res_tgt_q    <= '0;
			pend_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// The result register fills in S_OUT and empties once the receiver takes it.
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_dec_q <= 1'b0;
						res_tgt_q <= '0;
						if (!is_end || (cpu_in_ext >= NUM_EXT)) begin
							state_q <= S_OUT;
						end else if (cmd == CMD_AWARD) begin
							state_q <= S_AW0;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD:    state_q <= S_DELTA;
				S_DELTA: state_q <= S_BUSY;
				S_BUSY: begin
					if (ws_q == '0) begin
						ws_q <= now_q;
					end
					state_q <= S_TT;
				end
				S_TT: begin
					res_dec_q <= 1'b1;
					state_q   <= S_WIN;
				end
				S_WIN:   state_q <= S_WCMP;
				S_WCMP: begin
					pend_s1 <= 1'b0;
					if (alu_carry) begin
						state_q <= S_SCAN;
					end else begin
						least_pick_q <= PICK_NONE;
						most_pick_q  <= PICK_NONE;
						state_q      <= S_OUT;
					end
				end
				S_SCAN: begin
					pend_s1 <= scan_issue;
					if (!scan_issue && !pend_s1) begin
						least_pick_q <= lo_q;
						most_pick_q  <= hi_q;
						state_q      <= S_OUT;
					end
				end
				S_AW0:   state_q <= S_AW1;
				S_AW1:   state_q <= S_AW2;
				S_AW2:   state_q <= S_AW3;
				S_AW3: begin
					if (mig) begin
						ws_q         <= '0;
						least_pick_q <= PICK_NONE;
						most_pick_q  <= PICK_NONE;
						res_dec_q    <= 1'b1;
						res_tgt_q    <= least_pick_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign decision        = decision_q;
	assign thread_time_out = tt_out_q;
	assign migrate_target  = target_q;
	assign least_cpu_out   = least_out_q;
	assign most_cpu_out    = most_out_q;

	// An accepted transaction always moves the sequencer out of idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted transaction left the sequencer idle");

	// A proposed migration closes the window and clears both picks.
	a_mig_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AW3 && mig) |=> (ws_q == '0 && least_pick_q == PICK_NONE &&
			most_pick_q == PICK_NONE))
		else $error("migration did not clear window and picks");

	// A nonzero migration target only comes with a positive decision.
	a_target_dec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (decision_q || target_q == 3'd0))
		else $error("migration target without decision");

	// Picks never exceed the none code while the sequencer is in S_OUT.
	a_pick_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (least_pick_q <= PICK_NONE && most_pick_q <= PICK_NONE))
		else $error("pick out of range");

endmodule
